// ===== hw/rtl/umf_pkg.sv =====
// ----------------------------------------------------------------------------
// umf_pkg
// shared constants, types and helpers of the unique mode finder
// ----------------------------------------------------------------------------
package umf_pkg;

    localparam int DEPTH           = 16;
    localparam int VALUE_BITS      = 32;
    localparam int IN_VALUE_BITS   = 32;
    localparam int MODE_COUNT_BITS = 5;
    localparam int COUNT_SAT       = 31;
    localparam int ADDR_BITS       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS      = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
    } cell_t;

    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
        cell_t                wdata;
    } ram_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SCAN_OPEN,
        ST_SCAN
    } state_t;

    function automatic logic [VALUE_BITS-1:0] trim_value(input logic [IN_VALUE_BITS-1:0] v);
        logic [VALUE_BITS+IN_VALUE_BITS-1:0] wide;
        wide = {{VALUE_BITS{1'b0}}, v};
        return wide[VALUE_BITS-1:0];
    endfunction

    function automatic logic [IN_VALUE_BITS-1:0] ext_value(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS+IN_VALUE_BITS-1:0] wide;
        wide = {{IN_VALUE_BITS{v[VALUE_BITS-1]}}, v};
        return wide[IN_VALUE_BITS-1:0];
    endfunction

    function automatic logic [MODE_COUNT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS+MODE_COUNT_BITS-1:0] wide;
        wide = (COUNT_BITS + MODE_COUNT_BITS)'(c);
        if (wide > (COUNT_BITS + MODE_COUNT_BITS)'(COUNT_SAT))
            return MODE_COUNT_BITS'(COUNT_SAT);
        else
            return wide[MODE_COUNT_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/umf_cell_ram.sv =====
// ----------------------------------------------------------------------------
// umf_cell_ram
// cell store: value and count per cell, one write and one registered read
// ----------------------------------------------------------------------------
module umf_cell_ram (
    input  logic             clk,
    input  umf_pkg::ram_req_t req,
    output umf_pkg::cell_t    rd_data
);
    import umf_pkg::*;

    cell_t mem [DEPTH];
    cell_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/umf_ctrl.sv =====
// ----------------------------------------------------------------------------
// umf_ctrl
// sequencer: per-item cell search and update, end-of-set scan for the mode
// ----------------------------------------------------------------------------
module umf_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [umf_pkg::IN_VALUE_BITS-1:0]    sample_value,
    input  logic                                 set_end,
    output logic                                 busy,
    output logic                                 done,
    output logic                                 mode_exists,
    output logic [umf_pkg::IN_VALUE_BITS-1:0]    mode_value,
    output logic [umf_pkg::MODE_COUNT_BITS-1:0]  mode_count,
    output logic                                 set_overflow,
    output umf_pkg::ram_req_t                    req,
    input  umf_pkg::cell_t                       rd_data
);
    import umf_pkg::*;

    state_t                      state_reg, state_next;
    logic [ADDR_BITS-1:0]        idx_reg, idx_next;
    logic [COUNT_BITS-1:0]       fill_reg, fill_next;
    logic [COUNT_BITS-1:0]       items_reg, items_next;
    logic                        ovf_reg, ovf_next;
    logic [VALUE_BITS-1:0]       sample_reg, sample_next;
    logic                        end_reg, end_next;
    logic [COUNT_BITS-1:0]       best_reg, best_next;
    logic [COUNT_BITS-1:0]       ties_reg, ties_next;
    logic [VALUE_BITS-1:0]       bval_reg, bval_next;
    logic                        done_reg, done_next;
    logic                        exists_reg, exists_next;
    logic [IN_VALUE_BITS-1:0]    value_reg, value_next;
    logic [MODE_COUNT_BITS-1:0]  count_reg, count_next;
    logic                        ovf_out_reg, ovf_out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            items_reg <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            items_reg <= items_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        sample_reg  <= sample_next;
        end_reg     <= end_next;
        best_reg    <= best_next;
        ties_reg    <= ties_next;
        bval_reg    <= bval_next;
        exists_reg  <= exists_next;
        value_reg   <= value_next;
        count_reg   <= count_next;
        ovf_out_reg <= ovf_out_next;
    end

    always_comb
    begin
        logic [VALUE_BITS-1:0] v;
        logic [COUNT_BITS-1:0] nb;
        logic [COUNT_BITS-1:0] nt;
        logic [VALUE_BITS-1:0] nv;

        state_next   = state_reg;
        idx_next     = idx_reg;
        fill_next    = fill_reg;
        items_next   = items_reg;
        ovf_next     = ovf_reg;
        sample_next  = sample_reg;
        end_next     = end_reg;
        best_next    = best_reg;
        ties_next    = ties_reg;
        bval_next    = bval_reg;
        done_next    = 1'b0;
        exists_next  = exists_reg;
        value_next   = value_reg;
        count_next   = count_reg;
        ovf_out_next = ovf_out_reg;
        req          = '0;
        v            = trim_value(sample_value);
        nb           = best_reg;
        nt           = ties_reg;
        nv           = bval_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (items_reg >= COUNT_BITS'(DEPTH))
                    begin
                        ovf_next = 1'b1;
                        if (set_end)
                            state_next = ST_SCAN_OPEN;
                    end
                    else
                    begin
                        items_next  = items_reg + 1'b1;
                        sample_next = v;
                        end_next    = set_end;
                        if (fill_reg == '0)
                        begin
                            req.wr_en         = 1'b1;
                            req.wr_addr       = '0;
                            req.wdata.value   = v;
                            req.wdata.count   = COUNT_BITS'(1);
                            fill_next         = COUNT_BITS'(1);
                            if (set_end)
                                state_next = ST_SCAN_OPEN;
                        end
                        else
                        begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = '0;
                            idx_next    = '0;
                            state_next  = ST_SEARCH;
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                if (rd_data.value == sample_reg)
                begin
                    req.wr_en       = 1'b1;
                    req.wr_addr     = idx_reg;
                    req.wdata.value = rd_data.value;
                    req.wdata.count = rd_data.count + 1'b1;
                    state_next      = end_reg ? ST_SCAN_OPEN : ST_IDLE;
                end
                else if (COUNT_BITS'(idx_reg) + 1'b1 == fill_reg)
                begin
                    // no match among used cells: open a new one
                    req.wr_en       = 1'b1;
                    req.wr_addr     = fill_reg[ADDR_BITS-1:0];
                    req.wdata.value = sample_reg;
                    req.wdata.count = COUNT_BITS'(1);
                    fill_next       = fill_reg + 1'b1;
                    state_next      = end_reg ? ST_SCAN_OPEN : ST_IDLE;
                end
                else
                begin
                    idx_next    = idx_reg + 1'b1;
                    req.rd_en   = 1'b1;
                    req.rd_addr = idx_reg + 1'b1;
                end
            end

            ST_SCAN_OPEN:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = '0;
                idx_next    = '0;
                best_next   = '0;
                ties_next   = '0;
                state_next  = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (rd_data.count > best_reg)
                begin
                    nb = rd_data.count;
                    nt = COUNT_BITS'(1);
                    nv = rd_data.value;
                end
                else if (rd_data.count == best_reg)
                begin
                    nt = ties_reg + 1'b1;
                end
                best_next = nb;
                ties_next = nt;
                bval_next = nv;
                if (COUNT_BITS'(idx_reg) + 1'b1 == fill_reg)
                begin
                    done_next    = 1'b1;
                    exists_next  = (nt == COUNT_BITS'(1));
                    value_next   = (nt == COUNT_BITS'(1)) ? ext_value(nv) : '0;
                    count_next   = (nt == COUNT_BITS'(1)) ? sat_count(nb) : '0;
                    ovf_out_next = ovf_reg;
                    fill_next    = '0;
                    items_next   = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    idx_next    = idx_reg + 1'b1;
                    req.rd_en   = 1'b1;
                    req.rd_addr = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign mode_exists  = exists_reg;
    assign mode_value   = value_reg;
    assign mode_count   = count_reg;
    assign set_overflow = ovf_out_reg;

endmodule

// ===== hw/rtl/unique_mode_finder_unit.sv =====
// ----------------------------------------------------------------------------
// unique_mode_finder_unit
// loads a set of signed values and reports its unique mode, if any
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item is looked up
// against the cells filled so far through the cell store's single read port,
// one cell per cycle, with busy high until a cell matches or, when none does,
// a new cell is opened; the first item of a set and items dropped on overflow
// are taken without a search. Closing a set adds a scan that opens and then
// reads each used cell in turn, and the result then shows on done for a single
// cycle. The result cannot be held off; done is not held, but the result outputs
// keep their values until the next result. Stores clear as the result leaves,
// so the next set may start right away.
module unique_mode_finder_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [umf_pkg::IN_VALUE_BITS-1:0]    sample_value,
    input  logic                                 set_end,
    output logic                                 busy,
    output logic                                 done,
    output logic                                 mode_exists,
    output logic [umf_pkg::IN_VALUE_BITS-1:0]    mode_value,
    output logic [umf_pkg::MODE_COUNT_BITS-1:0]  mode_count,
    output logic                                 set_overflow
);
    import umf_pkg::*;

    ram_req_t req;
    cell_t    rd_data;

    umf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .sample_value (sample_value),
        .set_end      (set_end),
        .busy         (busy),
        .done         (done),
        .mode_exists  (mode_exists),
        .mode_value   (mode_value),
        .mode_count   (mode_count),
        .set_overflow (set_overflow),
        .req          (req),
        .rd_data      (rd_data)
    );

    umf_cell_ram u_cell_ram (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

endmodule

// ===== hw/rtl/umf_checker.sv =====
// ----------------------------------------------------------------------------
// umf_checker
// port-level checks of the unique mode finder, bound to the top level
// ----------------------------------------------------------------------------
module umf_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 busy,
    input  logic                                 done,
    input  logic                                 mode_exists,
    input  logic [umf_pkg::IN_VALUE_BITS-1:0]    mode_value,
    input  logic [umf_pkg::MODE_COUNT_BITS-1:0]  mode_count
);
    import umf_pkg::*;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result transfer while still busy");

    a_no_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !mode_exists) |-> (mode_value == '0 && mode_count == '0))
        else $error("no-mode result carries nonzero value or count");

    a_mode_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_exists) |-> (mode_count != '0))
        else $error("mode reported with zero count");

endmodule

bind unique_mode_finder_unit umf_checker u_umf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .busy        (busy),
    .done        (done),
    .mode_exists (mode_exists),
    .mode_value  (mode_value),
    .mode_count  (mode_count)
);
